FILE: sv/rk4s_pkg.sv
`timescale 1ns / 1ps
package rk4s_pkg;

  localparam int MAX_STEPS = 16;
  localparam int FRAC_BITS = 16;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int PROD_W    = 54;
  localparam int SUM_W     = 36;
  localparam int QUO_W     = 34;
  localparam int DEN_W     = 19;

  // half of 6 * 2^16, rounding term of the final weighted update
  localparam int FINAL_HALF = 3 * 65536;

  // (2^35 + 1) / 3 split into two 17 bit halves for the shared multiplier;
  // (m * recip) >> 35 is m / 3 exactly for any m below 2^35
  localparam logic [16:0] RCP3_HI = 17'd87381;
  localparam logic [16:0] RCP3_LO = 17'd43691;

  localparam logic [2:0] CFG_STEP_SIZE = 3'd0;
  localparam logic [2:0] CFG_MAX_FRAME = 3'd1;
  localparam logic [2:0] CFG_STIFFNESS = 3'd2;
  localparam logic [2:0] CFG_DAMPING   = 3'd3;
  localparam logic [2:0] CFG_START_POS = 3'd4;
  localparam logic [2:0] CFG_START_VEL = 3'd5;

  typedef struct packed {
    logic                     start;
    logic                     rnd;
    logic signed [PROD_W-1:0] num;
    logic [DEN_W-1:0]         den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W+1:0] quo;
    logic [DEN_W-1:0]        rem;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // shift right with rounding to nearest, halves away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] p,
                                                 input logic [4:0] sh);
    logic [63:0] m;
    m = p[63] ? 64'(-p) : 64'(p);
    m = (m + (64'd1 << (sh - 5'd1))) >> sh;
    return p[63] ? -signed'(m) : signed'(m);
  endfunction

endpackage

FILE: sv/rk4s_div.sv
`timescale 1ns / 1ps
module rk4s_div (
  input  logic                clk,
  input  logic                rst,
  input  rk4s_pkg::div_req_t  req,
  output rk4s_pkg::div_rsp_t  rsp
);
  import rk4s_pkg::*;

  logic                 busy;
  logic [5:0]           cnt;
  logic                 neg;
  logic [DEN_W-1:0]     r;
  logic [QUO_W-1:0]     m;
  logic [QUO_W-1:0]     q;
  logic [DEN_W-1:0]     den;
  logic                 done;
  logic [PROD_W-1:0]    mag;
  logic [DEN_W:0]       t;
  logic                 qbit;

  always_comb begin
    mag = req.num[PROD_W-1] ? PROD_W'(-req.num) : PROD_W'(req.num);
    if (req.rnd) begin
      mag = mag + PROD_W'(req.den >> 1);
    end
    t    = {r, m[QUO_W-1]};
    qbit = (t >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= req.num[PROD_W-1];
        den  <= req.den;
        r    <= DEN_W'(mag >> QUO_W);
        m    <= mag[QUO_W-1:0];
      end else if (busy) begin
        r   <= qbit ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
        m   <= m << 1;
        q   <= {q[QUO_W-2:0], qbit};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = neg ? -signed'({2'b00, q}) : signed'({2'b00, q});
  assign rsp.rem  = r;

endmodule

FILE: sv/rk4_fixed_step_spring_integrator.sv
`timescale 1ns / 1ps
// channel  | dir | width | contents
// s_axis   | in  | 32    | elapsed_time
// m_axis   | out | 72    | blended_position, blended_velocity, steps_taken, steps_dropped
// cfg      | in  | 32    | write enable, 3 bit index, data
//
// steps_taken ranges over 0..16; a frame with zero step size goes straight to the output.
// The bit-serial divider (34 iterations a division) runs once for the step count
// and twice for the blend; each RK4 step runs on the shared multiplier, the divide
// by six of the final update done by reciprocal multiplication.
// Reset is synchronous; state comes up at the reset register values, no clearing pass.
// s_tready is high only while idle with no result waiting; a stalled result holds the input.
module rk4_fixed_step_spring_integrator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] elapsed_time
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] position, [63:32] velocity, [68:64] steps_taken,
                                 // [69] steps_dropped, [71:70] zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data
);
  import rk4s_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_WHOLE = 5'd1;
  localparam logic [4:0] ST_START = 5'd2;
  localparam logic [4:0] ST_MK    = 5'd3;
  localparam logic [4:0] ST_MB    = 5'd4;
  localparam logic [4:0] ST_AC    = 5'd5;
  localparam logic [4:0] ST_PX    = 5'd6;
  localparam logic [4:0] ST_PX2   = 5'd7;
  localparam logic [4:0] ST_PV    = 5'd8;
  localparam logic [4:0] ST_FX    = 5'd9;
  localparam logic [4:0] ST_FXS   = 5'd10;
  localparam logic [4:0] ST_FXW   = 5'd11;
  localparam logic [4:0] ST_FV    = 5'd12;
  localparam logic [4:0] ST_FVS   = 5'd13;
  localparam logic [4:0] ST_FVW   = 5'd14;
  localparam logic [4:0] ST_BP    = 5'd15;
  localparam logic [4:0] ST_BPS   = 5'd16;
  localparam logic [4:0] ST_BPW   = 5'd17;
  localparam logic [4:0] ST_BV    = 5'd18;
  localparam logic [4:0] ST_BVS   = 5'd19;
  localparam logic [4:0] ST_BVW   = 5'd20;
  localparam logic [4:0] ST_OUT   = 5'd21;
  localparam logic [4:0] ST_FXL   = 5'd22;
  localparam logic [4:0] ST_FXH   = 5'd23;
  localparam logic [4:0] ST_FVL   = 5'd24;
  localparam logic [4:0] ST_FVH   = 5'd25;

  logic [4:0]  state;
  logic [15:0] step_size, max_frame, stiffness, damping;
  logic signed [31:0] pn, vn, pb, vb, xs, vs, dx, dv, outp, outv;
  logic [16:0] tl;
  logic [STEP_W-1:0] taken, stepcnt;
  logic dropped;
  logic [1:0] stage;
  logic signed [SUM_W-1:0] sumx, sumv;
  logic signed [PROD_W-1:0] prod, acc;
  logic [QUO_W-1:0] rm;
  logic             rneg;

  logic signed [35:0] mul_a;
  logic [16:0] mul_b;
  logic [15:0] dt;
  logic [17:0] tl_sum;
  logic [4:0]  sh;
  logic signed [63:0] f;
  logic signed [31:0] a_new;
  logic [17:0] whole;
  logic        accept;
  logic [PROD_W-1:0] pmag, rsum;
  logic signed [PROD_W-1:0] q3_sum;
  logic [QUO_W-1:0] q3;
  logic signed [63:0] dq;
  div_req_t    dreq;
  div_rsp_t    drsp;

  rk4s_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {2'b00, dropped, taken, outv, outp};

  always_comb begin
    dt     = (s_tdata > {16'd0, max_frame}) ? max_frame : s_tdata[15:0];
    tl_sum = {1'b0, tl} + {2'b00, dt};
    sh     = (stage == 2'd2) ? 5'd16 : 5'd17;
    f      = 64'(acc) + 64'(prod);
    a_new  = sat32(-rnd_shr(f, 5'd8));
    whole  = drsp.quo[17:0];
    // final update: round the magnitude, drop 2^17, then divide by three
    pmag   = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    rsum   = pmag + PROD_W'(FINAL_HALF);
    q3_sum = prod + (acc >>> 17);
    q3     = q3_sum[QUO_W+17:18];
    dq     = rneg ? -signed'(64'(q3)) : signed'(64'(q3));
    mul_a  = '0;
    mul_b  = '0;
    unique case (state) inside
      ST_MK:  begin mul_a = 36'(xs); mul_b = {1'b0, stiffness}; end
      ST_MB:  begin mul_a = 36'(vs); mul_b = {1'b0, damping}; end
      ST_PX:  begin mul_a = 36'(dx); mul_b = {1'b0, step_size}; end
      ST_PX2: begin mul_a = 36'(dv); mul_b = {1'b0, step_size}; end
      ST_FX:  begin mul_a = sumx; mul_b = {1'b0, step_size}; end
      ST_FV:  begin mul_a = sumv; mul_b = {1'b0, step_size}; end
      ST_FXL, ST_FVL: begin mul_a = 36'({1'b0, rm}); mul_b = RCP3_LO; end
      ST_FXH, ST_FVH: begin mul_a = 36'({1'b0, rm}); mul_b = RCP3_HI; end
      ST_BP:  begin mul_a = 36'(33'(pn) - 33'(pb)); mul_b = tl; end
      ST_BV:  begin mul_a = 36'(33'(vn) - 33'(vb)); mul_b = tl; end
      default: begin end
    endcase
    dreq.start = 1'b0;
    dreq.rnd   = 1'b1;
    dreq.num   = prod;
    dreq.den   = DEN_W'(step_size);
    unique case (state) inside
      ST_IDLE: begin
        dreq.start = accept && (step_size != 16'd0);
        dreq.rnd   = 1'b0;
        dreq.num   = PROD_W'(tl_sum[16:0]);
      end
      ST_BPS, ST_BVS: dreq.start = 1'b1;
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a * signed'({1'b0, mul_b}));
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      step_size <= 16'd6554;
      max_frame <= 16'd16384;
      stiffness <= 16'd2560;
      damping   <= 16'd256;
      pn        <= 32'sd100 <<< FRAC_BITS;
      pb        <= 32'sd100 <<< FRAC_BITS;
      vn        <= '0;
      vb        <= '0;
      tl        <= '0;
      taken     <= '0;
      dropped   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_STEP_SIZE: step_size <= cfg_data[15:0];
          CFG_MAX_FRAME: max_frame <= cfg_data[15:0];
          CFG_STIFFNESS: stiffness <= cfg_data[15:0];
          CFG_DAMPING:   damping   <= cfg_data[15:0];
          CFG_START_POS: begin pn <= cfg_data; pb <= cfg_data; end
          CFG_START_VEL: begin vn <= cfg_data; vb <= cfg_data; end
          default: begin end
        endcase
      end
      unique case (state)
        ST_IDLE: if (accept) begin
          if (step_size == 16'd0) begin
            tl      <= '0;
            taken   <= '0;
            dropped <= 1'b0;
            outp    <= pb;
            outv    <= vb;
            state   <= ST_OUT;
          end else begin
            state <= ST_WHOLE;
          end
        end
        ST_WHOLE: if (drsp.done) begin
          tl      <= drsp.rem[16:0];
          stepcnt <= '0;
          dropped <= (whole > 18'(MAX_STEPS));
          taken   <= (whole > 18'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : STEP_W'(whole);
          state   <= (whole == 18'd0) ? ST_BP : ST_START;
        end
        ST_START: begin
          pb    <= pn;
          vb    <= vn;
          xs    <= pn;
          vs    <= vn;
          stage <= 2'd0;
          sumx  <= '0;
          sumv  <= '0;
          state <= ST_MK;
        end
        ST_MK: state <= ST_MB;
        ST_MB: begin
          acc   <= prod;
          state <= ST_AC;
        end
        ST_AC: begin
          dx <= vs;
          dv <= a_new;
          if (stage == 2'd0 || stage == 2'd3) begin
            sumx <= sumx + SUM_W'(vs);
            sumv <= sumv + SUM_W'(a_new);
          end else begin
            sumx <= sumx + (SUM_W'(vs) <<< 1);
            sumv <= sumv + (SUM_W'(a_new) <<< 1);
          end
          state <= (stage == 2'd3) ? ST_FX : ST_PX;
        end
        ST_PX: state <= ST_PX2;
        ST_PX2: begin
          xs    <= sat32(64'(pn) + rnd_shr(64'(prod), sh));
          state <= ST_PV;
        end
        ST_PV: begin
          vs    <= sat32(64'(vn) + rnd_shr(64'(prod), sh));
          stage <= stage + 2'd1;
          state <= ST_MK;
        end
        ST_FX:  state <= ST_FXS;
        ST_FXS: begin
          rm    <= rsum[QUO_W+16:17];
          rneg  <= prod[PROD_W-1];
          state <= ST_FXL;
        end
        ST_FXL: state <= ST_FXH;
        ST_FXH: begin
          acc   <= prod;
          state <= ST_FXW;
        end
        ST_FXW: begin
          pn    <= sat32(64'(pn) + dq);
          state <= ST_FV;
        end
        ST_FV:  state <= ST_FVS;
        ST_FVS: begin
          rm    <= rsum[QUO_W+16:17];
          rneg  <= prod[PROD_W-1];
          state <= ST_FVL;
        end
        ST_FVL: state <= ST_FVH;
        ST_FVH: begin
          acc   <= prod;
          state <= ST_FVW;
        end
        ST_FVW: begin
          vn      <= sat32(64'(vn) + dq);
          stepcnt <= stepcnt + 1'b1;
          state   <= (stepcnt + 1'b1 == taken) ? ST_BP : ST_START;
        end
        ST_BP:  state <= ST_BPS;
        ST_BPS: state <= ST_BPW;
        ST_BPW: if (drsp.done) begin
          outp  <= sat32(64'(pb) + 64'(drsp.quo));
          state <= ST_BV;
        end
        ST_BV:  state <= ST_BVS;
        ST_BVS: state <= ST_BVW;
        ST_BVW: if (drsp.done) begin
          outv  <= sat32(64'(vb) + 64'(drsp.quo));
          state <= ST_OUT;
        end
        ST_OUT: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          state    <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> (state == ST_WHOLE || state == ST_BPW || state == ST_BVW))
    else $error("divider finished outside a wait state");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_START) |-> (stepcnt < taken && taken <= STEP_W'(MAX_STEPS)))
    else $error("step count beyond frame limit");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_BP) |-> (17'(step_size) > tl))
    else $error("remaining time not below step size at blend");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!m_tvalid || m_tready)) |=> (m_tvalid && state == ST_IDLE))
    else $error("result not presented");

endmodule

FILE: tb/rk4_fixed_step_spring_integrator_test.sv
`timescale 1ns / 1ps
module rk4_fixed_step_spring_integrator_test;
  import rk4s_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] elapsed_time
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // [31:0] position, [63:32] velocity, [68:64] steps_taken,
                          // [69] steps_dropped, [71:70] zero
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_data;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic [4:0]         taken;
    logic               dropped;
  } frame_out_t;

  rk4_fixed_step_spring_integrator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // spring model state and registers
  longint unsigned step_q, clamp_q, k_q, b_q;
  longint pos_cur, vel_cur, pos_prev, vel_prev;
  longint unsigned accum;

  frame_out_t expected_frames[$];
  int errors;
  int hold_off;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("rk4_fixed_step_spring_integrator_test: errors");
    $finish;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n < 0) return -((-n + d / 2) / d);
    return (n + d / 2) / d;
  endfunction

  function automatic longint spring_accel(longint x, longint v);
    return clip32(-round_div(longint'(k_q) * x + longint'(b_q) * v, 256));
  endfunction

  task automatic rk4_advance();
    longint ax, av, bx, bv, cx, cv, dx, dv, xs, vs, sx, sv, h;
    h = longint'(step_q);
    ax = vel_cur;
    av = spring_accel(pos_cur, vel_cur);
    xs = clip32(pos_cur + round_div(ax * h, 131072));
    vs = clip32(vel_cur + round_div(av * h, 131072));
    bx = vs; bv = spring_accel(xs, vs);
    xs = clip32(pos_cur + round_div(bx * h, 131072));
    vs = clip32(vel_cur + round_div(bv * h, 131072));
    cx = vs; cv = spring_accel(xs, vs);
    xs = clip32(pos_cur + round_div(cx * h, 65536));
    vs = clip32(vel_cur + round_div(cv * h, 65536));
    dx = vs; dv = spring_accel(xs, vs);
    sx = ax + 2 * (bx + cx) + dx;
    sv = av + 2 * (bv + cv) + dv;
    pos_cur = clip32(pos_cur + round_div(sx * h, 6 * 65536));
    vel_cur = clip32(vel_cur + round_div(sv * h, 6 * 65536));
  endtask

  task automatic predict_frame(logic [31:0] elapsed);
    frame_out_t r;
    longint unsigned dt, whole;
    dt = elapsed;
    r = '0;
    if (dt > clamp_q) dt = clamp_q;
    if (step_q == 0) begin
      accum = 0;
      r.pos = 32'(pos_prev);
      r.vel = 32'(vel_prev);
    end else begin
      accum = (accum + dt) & 64'h1FFFF;
      whole = accum / step_q;
      accum -= whole * step_q;
      if (whole > MAX_STEPS) begin
        whole = MAX_STEPS;
        r.dropped = 1'b1;
      end
      r.taken = 5'(whole);
      repeat (whole) begin
        pos_prev = pos_cur;
        vel_prev = vel_cur;
        rk4_advance();
      end
      r.pos = 32'(clip32(pos_prev + round_div((pos_cur - pos_prev) * longint'(accum),
                                              longint'(step_q))));
      r.vel = 32'(clip32(vel_prev + round_div((vel_cur - vel_prev) * longint'(accum),
                                              longint'(step_q))));
    end
    expected_frames.push_back(r);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STEP_SIZE: step_q  = val[15:0];
      CFG_MAX_FRAME: clamp_q = val[15:0];
      CFG_STIFFNESS: k_q     = val[15:0];
      CFG_DAMPING:   b_q     = val[15:0];
      CFG_START_POS: begin
        pos_cur = longint'($signed(val));
        pos_prev = pos_cur;
      end
      CFG_START_VEL: begin
        vel_cur = longint'($signed(val));
        vel_prev = vel_cur;
      end
      default: ;
    endcase
  endtask

  // hold tvalid across back-to-back transactions; drop it only for a gap
  task automatic send_frame(logic [31:0] elapsed, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : int'($urandom_range(0, 3));
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= elapsed;
    do @(posedge clk); while (!s_tready);
    predict_frame(elapsed);
  endtask

  // wait out the block's own work before touching registers
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // result side: random stalls plus an optional long hold-off
  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        m_tready <= 1'b0;
        hold_off--;
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    frame_out_t g, w;
    if (!rst && m_tvalid && m_tready) begin
      g.pos     = m_tdata[31:0];
      g.vel     = m_tdata[63:32];
      g.taken   = m_tdata[68:64];
      g.dropped = m_tdata[69];
      if (expected_frames.size() == 0) begin
        report("unexpected transaction", 0, 0);
      end else begin
        w = expected_frames.pop_front();
        if (g.pos != w.pos) report("position", g.pos, w.pos);
        if (g.vel != w.vel) report("velocity", g.vel, w.vel);
        if (g.taken != w.taken) report("steps_taken", g.taken, w.taken);
        if (g.dropped != w.dropped) report("steps_dropped", g.dropped, w.dropped);
      end
    end
  end

  task automatic test_reset_defaults();
    send_frame(32'd0);
    send_frame(32'd6554);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'd16384);
    send_frame(32'd1);
    drain();
  endtask

  task automatic test_extremes();
    write_reg(CFG_MAX_FRAME, 32'd65535);
    write_reg(CFG_STEP_SIZE, 32'd1024);
    write_reg(CFG_STIFFNESS, 32'd65535);
    write_reg(CFG_DAMPING, 32'd65535);
    write_reg(CFG_START_POS, 32'h7FFF_FFFF);
    write_reg(CFG_START_VEL, 32'h8000_0000);
    // too many steps in one frame
    send_frame(32'd65535);
    send_frame(32'hAAAA_5555);
    drain();
    write_reg(CFG_STIFFNESS, 32'd0);
    write_reg(CFG_DAMPING, 32'd0);
    write_reg(CFG_START_POS, 32'h8000_0000);
    write_reg(CFG_START_VEL, 32'h7FFF_FFFF);
    send_frame(32'h5555_AAAA);
    drain();
    write_reg(CFG_STEP_SIZE, 32'd65535);
    send_frame(32'd65535);
    send_frame(32'd65535);
    drain();
    // zero step size and zero clamp
    write_reg(CFG_STEP_SIZE, 32'd0);
    send_frame(32'd40000);
    drain();
    write_reg(CFG_STEP_SIZE, 32'd3000);
    write_reg(CFG_MAX_FRAME, 32'd0);
    send_frame(32'd40000);
    drain();
  endtask

  task automatic test_random_frames(int n);
    write_reg(CFG_MAX_FRAME, 32'd65535);
    write_reg(CFG_START_POS, 32'(100 << FRAC_BITS));
    write_reg(CFG_START_VEL, 32'd0);
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_STEP_SIZE, $urandom_range(1024, 65535));
      write_reg(CFG_MAX_FRAME, $urandom_range(1, 65535));
      write_reg(CFG_STIFFNESS, $urandom_range(0, 65535));
      write_reg(CFG_DAMPING, $urandom_range(0, 4095));
      write_reg(CFG_START_POS, $urandom);
      write_reg(CFG_START_VEL, $urandom);
      for (int i = 0; i < n / 6; i++) begin
        // mostly plausible frame times, sometimes anything
        if ($urandom_range(0, 4) == 0) send_frame($urandom);
        else send_frame($urandom_range(0, 20000), ph == 5);
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    write_reg(CFG_STEP_SIZE, 32'd6554);
    write_reg(CFG_MAX_FRAME, 32'd16384);
    hold_off = 3000;
    for (int i = 0; i < 6; i++) send_frame($urandom_range(0, 16384), 1);
    drain();
    // sender pauses until everything is back
    send_frame(32'd13108);
    drain();
  endtask

  initial begin
    errors   = 0;
    hold_off = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    cfg_we   = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    step_q = 6554; clamp_q = 16384; k_q = 2560; b_q = 256;
    pos_cur = 100 * 65536; pos_prev = pos_cur;
    vel_cur = 0; vel_prev = 0;
    accum = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_extremes();
    test_backpressure();
    test_random_frames(880);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("rk4_fixed_step_spring_integrator_test: clean");
    end else begin
      $display("rk4_fixed_step_spring_integrator_test: errors");
    end
    $finish;
  end

endmodule
